// ----- design/euler_rusanov_interface_flux_core_defines.svh -----
// Assertion macros for the Rusanov flux core.
`ifndef EULER_RUSANOV_INTERFACE_FLUX_CORE_DEFINES_SVH
`define EULER_RUSANOV_INTERFACE_FLUX_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a implies b in the same cycle.
`define ERIF_ASSERT_SAME(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");
// Check that a implies b in the next cycle.
`define ERIF_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ERIF_ASSERT_SAME(lbl, a, b)
`define ERIF_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- design/erif_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package erif_pkg;
  localparam int FRAC_BITS = 24;
  // round(0.4 * 2^F)
  localparam longint GAMMA_M1 = ((longint'(4) <<< FRAC_BITS) + 5) / 10;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int SIDE_LAT  = DIV_LAT + 7;
  localparam int PIPE_LAT  = SIDE_LAT + 2;
  localparam int SAT_W     = 72;

  typedef logic signed [31:0]      fx_t;
  typedef logic signed [SAT_W-1:0] wide_t;

  localparam wide_t FX_MAX = wide_t'(64'sh0000_0000_7FFF_FFFF);
  localparam wide_t FX_MIN = wide_t'(-64'sh0000_0000_8000_0000);

  function automatic fx_t sat32(input wide_t x);
    fx_t r;
    if (x > FX_MAX) r = 32'sh7FFF_FFFF;
    else if (x < FX_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/erif_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined signed velocity divide: u = sat(trunc((m << F) / rho)), one quotient bit per stage.
module erif_divider (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire erif_pkg::fx_t       rho,
  input  wire erif_pkg::fx_t       mom,
  output erif_pkg::fx_t            u
);
  localparam int F = erif_pkg::FRAC_BITS;
  localparam int N = erif_pkg::DIV_STEPS;

  logic [30:0]     rem_r [N+1];
  logic [31:0]     w_r   [N+1];
  logic [30:0]     d_r   [N+1];
  logic            ovf_r [N+1];
  logic            neg_r [N+1];
  logic [30:0]     rem_nxt [N];
  logic [31:0]     w_nxt   [N];
  erif_pkg::fx_t   u_r, u_nxt;

  logic [31:0]     mag;
  logic [31+F:0]   a;
  logic [F-1:0]    hi;
  logic            ovf0;
  logic [31:0]     tri_v [N];
  logic            ge    [N];

  always_comb begin
    mag  = mom[31] ? (~mom + 32'd1) : mom;
    a    = {mag, {F{1'b0}}};
    hi   = a[31+F:32];
    ovf0 = 32'(hi) >= 32'(rho[30:0]);
    for (int k = 0; k < N; k++) begin
      tri_v[k]   = {rem_r[k], w_r[k][31]};
      ge[k]      = tri_v[k] >= {1'b0, d_r[k]};
      rem_nxt[k] = ge[k] ? 31'(tri_v[k] - {1'b0, d_r[k]}) : tri_v[k][30:0];
      w_nxt[k]   = {w_r[k][30:0], ge[k]};
    end
    if (neg_r[N]) begin
      if (ovf_r[N] || w_r[N] > 32'h8000_0000) u_nxt = 32'sh8000_0000;
      else u_nxt = erif_pkg::fx_t'(~w_r[N] + 32'd1);
    end else begin
      if (ovf_r[N] || w_r[N][31]) u_nxt = 32'sh7FFF_FFFF;
      else u_nxt = erif_pkg::fx_t'(w_r[N]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= ovf0 ? 31'd0 : 31'(hi);
      w_r[0]   <= a[31:0];
      d_r[0]   <= rho[30:0];
      ovf_r[0] <= ovf0;
      neg_r[0] <= mom[31];
      for (int k = 0; k < N; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        w_r[k+1]   <= w_nxt[k];
        d_r[k+1]   <= d_r[k];
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
      u_r <= u_nxt;
    end
  end

  assign u = u_r;
endmodule
`default_nettype wire

// ----- design/erif_side_flux.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Physical Euler flux of one side state.
module erif_side_flux (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire erif_pkg::fx_t rho,
  input  wire erif_pkg::fx_t mom,
  input  wire erif_pkg::fx_t ene,
  output erif_pkg::fx_t      f0,
  output erif_pkg::fx_t      f1,
  output erif_pkg::fx_t      f2
);
  localparam int F  = erif_pkg::FRAC_BITS;
  localparam int DL = erif_pkg::DIV_LAT;
  localparam logic signed [F:0] G = (F+1)'(erif_pkg::GAMMA_M1);

  erif_pkg::fx_t u;
  erif_pkg::fx_t md_r [DL];
  erif_pkg::fx_t ed_r [DL];

  logic signed [63:0]  mu_r;
  erif_pkg::fx_t       u_a_r, m_a_r, e_a_r;
  erif_pkg::fx_t       ke_r, u_b_r, m_b_r, e_b_r;
  logic signed [63:0]  muf_b_r, muf_c_r, muf_d_r;
  logic signed [33+F:0] pm_r;
  erif_pkg::fx_t       u_c_r, m_c_r, e_c_r;
  erif_pkg::fx_t       p_r, u_d_r, m_d_r, e_d_r;
  erif_pkg::fx_t       h_r, f1e_r, u_e_r, m_e_r;
  logic signed [63:0]  hu_r;
  erif_pkg::fx_t       f1f_r, m_f_r;
  erif_pkg::fx_t       f0_r, f1_r, f2_r;
  logic signed [32:0]  e_minus_ke;

  erif_divider u_div (
    .clk (clk),
    .adv (adv),
    .rho (rho),
    .mom (mom),
    .u   (u)
  );

  assign e_minus_ke = 33'(e_b_r) - 33'(ke_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      md_r[0] <= mom;
      ed_r[0] <= ene;
      for (int k = 1; k < DL; k++) begin
        md_r[k] <= md_r[k-1];
        ed_r[k] <= ed_r[k-1];
      end
      // multiply momentum by velocity
      mu_r  <= 64'(md_r[DL-1]) * 64'(u);
      u_a_r <= u;
      m_a_r <= md_r[DL-1];
      e_a_r <= ed_r[DL-1];
      // kinetic energy and momentum flux term
      ke_r    <= erif_pkg::sat32(erif_pkg::SAT_W'(mu_r >>> (F + 1)));
      muf_b_r <= mu_r >>> F;
      u_b_r   <= u_a_r;
      m_b_r   <= m_a_r;
      e_b_r   <= e_a_r;
      // pressure product
      pm_r    <= (34+F)'(e_minus_ke) * (34+F)'(G);
      muf_c_r <= muf_b_r;
      u_c_r   <= u_b_r;
      m_c_r   <= m_b_r;
      e_c_r   <= e_b_r;
      // pressure
      p_r     <= erif_pkg::sat32(erif_pkg::SAT_W'(pm_r >>> F));
      muf_d_r <= muf_c_r;
      u_d_r   <= u_c_r;
      m_d_r   <= m_c_r;
      e_d_r   <= e_c_r;
      // enthalpy and momentum flux
      h_r   <= erif_pkg::sat32(erif_pkg::SAT_W'(e_d_r) + erif_pkg::SAT_W'(p_r));
      f1e_r <= erif_pkg::sat32(erif_pkg::SAT_W'(muf_d_r) + erif_pkg::SAT_W'(p_r));
      u_e_r <= u_d_r;
      m_e_r <= m_d_r;
      // energy flux product
      hu_r  <= 64'(h_r) * 64'(u_e_r);
      f1f_r <= f1e_r;
      m_f_r <= m_e_r;
      // output
      f2_r <= erif_pkg::sat32(erif_pkg::SAT_W'(hu_r >>> F));
      f1_r <= f1f_r;
      f0_r <= m_f_r;
    end
  end

  assign f0 = f0_r;
  assign f1 = f1_r;
  assign f2 = f2_r;
endmodule
`default_nettype wire

// ----- design/euler_rusanov_interface_flux_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Rusanov interface flux for 1-D ideal-gas Euler, gamma 1.4, signed Q8.24.
// Takes one item per clock while in_stall is low and returns one result item per
// input item, in order. After an input register the depth is set by the velocity
// divide, which resolves one quotient bit per pipeline stage (32 stages plus
// setup and saturation), followed by seven multiply and saturate stages for
// each side's physical flux and one stage that forms the average minus the
// dissipation term. The whole pipe holds while a result is stalled at the
// output; in_stall rises only then. A density at or below zero on either side
// yields zero fluxes with bad_density set. Write cfg_wave_speed only while idle.
`include "euler_rusanov_interface_flux_core_defines.svh"
module euler_rusanov_interface_flux_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [30:0]   cfg_wave_speed,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire erif_pkg::fx_t in_left_density,
  input  wire erif_pkg::fx_t in_left_momentum,
  input  wire erif_pkg::fx_t in_left_energy,
  input  wire erif_pkg::fx_t in_right_density,
  input  wire erif_pkg::fx_t in_right_momentum,
  input  wire erif_pkg::fx_t in_right_energy,
  output logic               out_valid,
  input  wire logic          out_stall,
  output erif_pkg::fx_t      out_mass_flux,
  output erif_pkg::fx_t      out_momentum_flux,
  output erif_pkg::fx_t      out_energy_flux,
  output logic               out_bad_density
);
  localparam int F  = erif_pkg::FRAC_BITS;
  localparam int SL = erif_pkg::SIDE_LAT;
  localparam int PL = erif_pkg::PIPE_LAT;

  logic        adv;
  logic [30:0] ws_r;
  logic        vld_r [PL];

  // input stage
  erif_pkg::fx_t ul_r [3];
  erif_pkg::fx_t ur_r [3];
  logic          bad0_r;

  erif_pkg::fx_t fl [3];
  erif_pkg::fx_t fr [3];

  logic signed [64:0] dis_r [3][SL];
  logic               bad_r [SL];
  logic signed [64:0] prod  [3];
  logic signed [32:0] diff  [3];
  logic signed [31:0] ws_s;

  erif_pkg::fx_t flux_r [3];
  erif_pkg::fx_t flux_nxt [3];
  logic          bad_out_r;
  logic signed [32:0] avg [3];

  // Advance everything unless a finished result is held by the sink.
  assign adv      = !(vld_r[PL-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= '0;
    end else if (cfg_we) begin
      ws_r <= cfg_wave_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PL; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < PL; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ul_r[0] <= in_left_density;
      ul_r[1] <= in_left_momentum;
      ul_r[2] <= in_left_energy;
      ur_r[0] <= in_right_density;
      ur_r[1] <= in_right_momentum;
      ur_r[2] <= in_right_energy;
      bad0_r  <= (in_left_density <= 32'sd0) || (in_right_density <= 32'sd0);
    end
  end

  erif_side_flux u_left (
    .clk (clk),
    .adv (adv),
    .rho (ul_r[0]),
    .mom (ul_r[1]),
    .ene (ul_r[2]),
    .f0  (fl[0]),
    .f1  (fl[1]),
    .f2  (fl[2])
  );

  erif_side_flux u_right (
    .clk (clk),
    .adv (adv),
    .rho (ur_r[0]),
    .mom (ur_r[1]),
    .ene (ur_r[2]),
    .f0  (fr[0]),
    .f1  (fr[1]),
    .f2  (fr[2])
  );

  // Dissipation: wave speed times state jump, shifted, then delayed to meet
  // the side fluxes.
  always_comb begin
    ws_s = signed'({1'b0, ws_r});
    for (int k = 0; k < 3; k++) begin
      diff[k] = 33'(ur_r[k]) - 33'(ul_r[k]);
      prod[k] = 65'(ws_s) * 65'(diff[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad_r[0] <= bad0_r;
      for (int j = 1; j < SL; j++) bad_r[j] <= bad_r[j-1];
      for (int k = 0; k < 3; k++) begin
        dis_r[k][0] <= prod[k] >>> (F + 1);
        for (int j = 1; j < SL; j++) dis_r[k][j] <= dis_r[k][j-1];
      end
    end
  end

  // Combine: average of side fluxes minus dissipation; drop to zero on a bad
  // density.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      avg[k] = (33'(fl[k]) + 33'(fr[k])) >>> 1;
      if (bad_r[SL-1]) flux_nxt[k] = '0;
      else flux_nxt[k] = erif_pkg::sat32(erif_pkg::SAT_W'(avg[k])
                                         - erif_pkg::SAT_W'(dis_r[k][SL-1]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) flux_r[k] <= flux_nxt[k];
      bad_out_r <= bad_r[SL-1];
    end
  end

  assign out_valid         = vld_r[PL-1];
  assign out_mass_flux     = flux_r[0];
  assign out_momentum_flux = flux_r[1];
  assign out_energy_flux   = flux_r[2];
  assign out_bad_density   = bad_out_r;

  `ERIF_ASSERT_SAME(a_bad_zero, out_valid && out_bad_density, out_mass_flux == 32'sd0 && out_momentum_flux == 32'sd0 && out_energy_flux == 32'sd0)
  `ERIF_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(out_mass_flux) && $stable(out_energy_flux))
  `ERIF_ASSERT_SAME(a_stall_only_on_block, in_stall, out_valid && out_stall)
endmodule
`default_nettype wire

// ----- sim/euler_rusanov_interface_flux_core_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
module euler_rusanov_interface_flux_core_test;
  localparam int FB = erif_pkg::FRAC_BITS;
  localparam int N_RANDOM = 800;
  localparam int DRAIN_CYCLES = erif_pkg::PIPE_LAT + 20;

  typedef struct packed {
    erif_pkg::fx_t mass;
    erif_pkg::fx_t mom;
    erif_pkg::fx_t energy;
    logic bad;
  } flux_t;

  // Clamp an exact value to the signed 32-bit range.
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Work out the physical flux of one side; rho is positive.
  function automatic void side_flux(input longint rho, input longint m, input longint e,
                                    output longint f0, output longint f1, output longint f2);
    longint vel, mu, ke, p, h;
    vel = clamp32((m <<< FB) / rho);
    mu = m * vel;
    ke = clamp32(mu >>> (FB + 1));
    p = clamp32(((e - ke) * erif_pkg::GAMMA_M1) >>> FB);
    h = clamp32(e + p);
    f0 = m;
    f1 = clamp32((mu >>> FB) + p);
    f2 = clamp32((h * vel) >>> FB);
  endfunction

  // Predict one interface flux from both states and the wave speed.
  function automatic flux_t predict_flux(input erif_pkg::fx_t ld, input erif_pkg::fx_t lm,
                                         input erif_pkg::fx_t le, input erif_pkg::fx_t rd,
                                         input erif_pkg::fx_t rm, input erif_pkg::fx_t re,
                                         input logic [30:0] speed);
    longint fl[3], fr[3], ul[3], ur[3], avg, dis;
    flux_t r;
    r = '0;
    if (ld <= 0 || rd <= 0) begin
      r.bad = 1'b1;
      return r;
    end
    ul[0] = ld; ul[1] = lm; ul[2] = le;
    ur[0] = rd; ur[1] = rm; ur[2] = re;
    side_flux(ld, lm, le, fl[0], fl[1], fl[2]);
    side_flux(rd, rm, re, fr[0], fr[1], fr[2]);
    for (int k = 0; k < 3; k++) begin
      avg = (fl[k] + fr[k]) >>> 1;
      dis = (longint'(speed) * (ur[k] - ul[k])) >>> (FB + 1);
      if (k == 0) r.mass = erif_pkg::fx_t'(clamp32(avg - dis));
      else if (k == 1) r.mom = erif_pkg::fx_t'(clamp32(avg - dis));
      else r.energy = erif_pkg::fx_t'(clamp32(avg - dis));
    end
    return r;
  endfunction

  class flux_scoreboard;
    flux_t pending_flux[$];
    int mismatches = 0;

    function void note_item(flux_t f);
      pending_flux.push_back(f);
    endfunction

    function void check_result(flux_t got);
      flux_t want;
      if (pending_flux.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      want = pending_flux.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("flux mismatch: expected m=%h p=%h e=%h bad=%b, got m=%h p=%h e=%h bad=%b",
                   want.mass, want.mom, want.energy, want.bad,
                   got.mass, got.mom, got.energy, got.bad);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wave_speed = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  erif_pkg::fx_t in_ld = '0, in_lm = '0, in_le = '0, in_rd = '0, in_rm = '0, in_re = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  erif_pkg::fx_t out_mass, out_mom, out_energy;
  logic out_bad;

  logic [30:0] wave_speed_now = '0;
  flux_scoreboard board = new();
  bit hold_long = 1'b0;
  bit sender_done = 1'b0;

  euler_rusanov_interface_flux_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wave_speed(cfg_wave_speed),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_density(in_ld), .in_left_momentum(in_lm), .in_left_energy(in_le),
    .in_right_density(in_rd), .in_right_momentum(in_rm), .in_right_energy(in_re),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mass_flux(out_mass), .out_momentum_flux(out_mom),
    .out_energy_flux(out_energy), .out_bad_density(out_bad)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Write the wave speed while the pipe is empty.
  task automatic write_speed(input logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_wave_speed <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    wave_speed_now = v;
  endtask

  // Offer one item, optionally after a random gap, and hold it until accepted.
  task automatic send_item(input erif_pkg::fx_t ld, input erif_pkg::fx_t lm,
                           input erif_pkg::fx_t le, input erif_pkg::fx_t rd,
                           input erif_pkg::fx_t rm, input erif_pkg::fx_t re,
                           input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(8, 0) : 0;
    if ($urandom_range(3, 0) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ld <= ld; in_lm <= lm; in_le <= le;
    in_rd <= rd; in_rm <= rm; in_re <= re;
    do @(posedge clk); while (in_stall);
    board.note_item(predict_flux(ld, lm, le, rd, rm, re, wave_speed_now));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  // Wait until every expected result has arrived, then let the pipe settle.
  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending_flux.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly physical-looking state: positive density, moderate momentum and energy, with an occasional raw random word.
  function automatic erif_pkg::fx_t rand_density();
    case ($urandom_range(9, 0))
      0: return erif_pkg::fx_t'($urandom_range(255, 1));
      1: return erif_pkg::fx_t'($urandom);
      default: return erif_pkg::fx_t'($urandom_range(32'h0800_0000, 32'h0040_0000));
    endcase
  endfunction

  function automatic erif_pkg::fx_t rand_field();
    if ($urandom_range(4, 0) == 0) return erif_pkg::fx_t'($urandom);
    return erif_pkg::fx_t'($signed($urandom_range(32'h0800_0000, 0)) - 32'sh0400_0000);
  endfunction

  task automatic random_phase(input int count);
    erif_pkg::fx_t ld, rd;
    for (int i = 0; i < count; i++) begin
      ld = rand_density();
      rd = rand_density();
      // Drop in a non-positive density now and then.
      if ($urandom_range(15, 0) == 0) ld = erif_pkg::fx_t'(-$signed($urandom_range(1000, 0)));
      if ($urandom_range(15, 0) == 0) rd = erif_pkg::fx_t'(32'h8000_0000 | $urandom);
      send_item(ld, rand_field(), rand_field(), rd, rand_field(), rand_field(),
                (i % 100) < 70);
    end
    idle_input();
  endtask

  // Receiver: random stall per item, with one long hold-off on request.
  initial begin
    int wait_cycles;
    out_stall <= 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        hold_long = 1'b0;
      end
      wait_cycles = $urandom_range(8, 0);
      if ($urandom_range(3, 0) == 0) wait_cycles = 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && !hold_long);
    end
  end

  // Check every accepted result item against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_mass, out_mom, out_energy, out_bad});
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, bad densities, tiny density, saturating states.
    write_speed(31'h7FFF_FFFF);
    send_item(32'sh0100_0000, 32'sh0100_0000, 32'sh0300_0000,
              32'sh0080_0000, '0, 32'sh0100_0000, 0);
    send_item('0, 32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, '0, '0, 0);
    send_item(32'sh0100_0000, '0, '0, 32'sh8000_0000, '0, '0, 0);
    send_item(32'shFFFF_FFFF, '0, '0, '0, '0, '0, 0);
    send_item(32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh0000_0001, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_item(32'sh0000_0001, 32'shFFFF_FFFF, '0, 32'sh7FFF_FFFF, 32'sh0000_0001, '0, 0);
    idle_input();
    drain();
    write_speed('0);
    send_item(32'sh0100_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh0000_0002, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_item(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
              32'sh2AAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 0);
    idle_input();
    drain();

    // Random phases across several wave speeds.
    write_speed(31'h0180_0000);
    random_phase(N_RANDOM / 4);
    // Hold the receiver off while the sender keeps offering items.
    hold_long = 1'b1;
    random_phase(N_RANDOM / 4);
    drain();
    write_speed(31'($urandom));
    random_phase(N_RANDOM / 4);
    drain();
    write_speed(31'h7FFF_FFFF);
    random_phase(N_RANDOM / 8);
    drain();
    write_speed('0);
    random_phase(N_RANDOM / 8);
    drain();

    if (board.mismatches == 0 && board.pending_flux.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
